// ===== sv/tvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoidal velocity step package
// Shared types and constants: profile modes, sign flags that travel with an
// item, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package tvs_pkg;

  // Profile mode reported with every result item.
  typedef enum logic [1:0] {
    MODE_STILL = 2'd0,
    MODE_ACCEL = 2'd1,
    MODE_CONST = 2'd2,
    MODE_DECEL = 2'd3
  } mode_e;

  // Sign information of the input item, carried down the pipeline.
  typedef struct packed {
    logic err_neg;
    logic err_zero;
    logic vel_neg;
  } flags_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_LIMIT = 1'b1;

  // Register reset values, unsigned Q7.16.
  localparam int unsigned VEL_LIMIT_RESET = 26214;
  localparam int unsigned ACC_LIMIT_RESET = 22938;

  // Number of register stages from input to output register.
  localparam int unsigned PIPE_STAGES = 5;

endpackage

// ===== sv/trapezoidal_velocity_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoidal velocity step
// One step of a trapezoidal velocity reference: picks still, accelerate,
// cruise or decelerate and returns the next signed velocity.
// ----------------------------------------------------------------------------
// The block is a five-stage pipeline that takes one item per clock while
// in_ready_o is high and returns the result items in order. Stage one takes
// magnitudes, stage two holds the three multipliers (step, squared speed,
// stopping product), stage three chooses the mode, stage four limits or snaps
// the speed and stage five rounds, signs and holds the result. Each stage has
// its own valid bit and loads when it is empty or its successor moves on, so
// input items keep being accepted into empty stages while a finished result
// waits for out_ready_i. The configuration port never stalls; limits are to be
// written through it only while no item is in flight, and nothing enforces it.
// ----------------------------------------------------------------------------
module trapezoidal_velocity_step #(
  parameter int unsigned VALUE_WIDTH   = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [VALUE_WIDTH-2:0]           cfg_data_i,
  // Input item channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0]    position_error_i,
  input  logic signed [VALUE_WIDTH-1:0]    current_velocity_i,
  input  logic [VALUE_WIDTH-5:0]           time_step_i,
  // Result item channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [VALUE_WIDTH-1:0]    new_velocity_o,
  output logic [1:0]                       profile_mode_o
);

  localparam int unsigned CW     = VALUE_WIDTH - 1;
  localparam int unsigned MW     = VALUE_WIDTH;
  localparam int unsigned STEP_W = 2 * VALUE_WIDTH - 4;
  localparam int unsigned SQ_W   = 2 * VALUE_WIDTH;
  localparam int unsigned WIDE_W = MW + FRACTION_BITS;
  localparam int unsigned SUM_W  = ((WIDE_W > STEP_W) ? WIDE_W : STEP_W) + 1;
  localparam int unsigned NS     = tvs_pkg::PIPE_STAGES;

  logic [CW-1:0]       vel_limit_q;
  logic [CW-1:0]       acc_limit_q;

  logic [NS-1:0]       valid_d, valid_q;
  logic [NS:0]         adv;
  logic [NS-1:0]       prev_valid;
  logic [NS-1:0]       load;

  logic [STEP_W-1:0]   f_step;
  logic [SQ_W-1:0]     f_sq;
  logic [SQ_W-1:0]     f_stop;
  logic [MW-1:0]       f_mag;
  logic [MW-1:0]       f_dx;
  tvs_pkg::flags_t     f_flags;

  tvs_pkg::mode_e      d_mode;
  logic [SUM_W-1:0]    d_sum;
  logic [WIDE_W-1:0]   d_diff;
  logic [STEP_W-1:0]   d_step;
  logic [MW-1:0]       d_mag;
  tvs_pkg::flags_t     d_flags;

  tvs_pkg::mode_e      s_mode;
  logic [MW-1:0]       out_mag;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_limit_q <= CW'(tvs_pkg::VEL_LIMIT_RESET);
      acc_limit_q <= CW'(tvs_pkg::ACC_LIMIT_RESET);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tvs_pkg::CFG_VEL_LIMIT: vel_limit_q <= cfg_data_i;
        tvs_pkg::CFG_ACC_LIMIT: acc_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage advances when it is empty or the next one does.
  always_comb begin
    adv[NS]    = out_ready_i;
    prev_valid = {valid_q[NS-2:0], in_valid_i};
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      valid_d[k] = adv[k] ? prev_valid[k] : valid_q[k];
      load[k]    = adv[k] && prev_valid[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[NS-1];

  // Datapath stages.
  tvs_front #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk_i              (clk_i),
    .load1_i            (load[0]),
    .load2_i            (load[1]),
    .accel_limit_i      (acc_limit_q),
    .position_error_i   (position_error_i),
    .current_velocity_i (current_velocity_i),
    .time_step_i        (time_step_i),
    .step_o             (f_step),
    .sq_o               (f_sq),
    .stop_o             (f_stop),
    .mag_o              (f_mag),
    .dx_o               (f_dx),
    .flags_o            (f_flags)
  );

  tvs_decide #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_decide (
    .clk_i            (clk_i),
    .load3_i          (load[2]),
    .velocity_limit_i (vel_limit_q),
    .step_i           (f_step),
    .sq_i             (f_sq),
    .stop_i           (f_stop),
    .mag_i            (f_mag),
    .dx_i             (f_dx),
    .flags_i          (f_flags),
    .mode_o           (d_mode),
    .sum_o            (d_sum),
    .diff_o           (d_diff),
    .step_o           (d_step),
    .mag_o            (d_mag),
    .flags_o          (d_flags)
  );

  tvs_shape #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_shape (
    .clk_i            (clk_i),
    .load4_i          (load[3]),
    .load5_i          (load[4]),
    .velocity_limit_i (vel_limit_q),
    .mode_i           (d_mode),
    .sum_i            (d_sum),
    .diff_i           (d_diff),
    .step_i           (d_step),
    .mag_i            (d_mag),
    .flags_i          (d_flags),
    .new_velocity_o   (new_velocity_o),
    .mode_o           (s_mode)
  );

  assign profile_mode_o = s_mode;

  // Magnitude of the outgoing velocity, for checking.
  assign out_mag = new_velocity_o[VALUE_WIDTH-1] ? (~$unsigned(new_velocity_o) + 1'b1)
                                                 : $unsigned(new_velocity_o);

  // A still item always leaves with zero velocity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (profile_mode_o == tvs_pkg::MODE_STILL) |-> new_velocity_o == '0)
    else $error("still item with nonzero velocity");

  // Acceleration never pushes the speed past the velocity limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (profile_mode_o == tvs_pkg::MODE_ACCEL) |->
      out_mag <= {1'b0, vel_limit_q})
    else $error("accelerated speed above velocity limit");

  // Input back-pressure only when every stage is full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q) && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // An item accepted into an idle pipeline occupies stage one in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (valid_q == '0) |=> valid_q[0])
    else $error("accepted item lost at stage one");

endmodule

// ===== sv/tvs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front stages
// Stage 1 takes magnitudes and signs of the inputs. Stage 2 forms the
// velocity step, the squared speed and the doubled stopping product.
// ----------------------------------------------------------------------------
module tvs_front #(
  parameter int unsigned VALUE_WIDTH   = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 load1_i,
  input  logic                                 load2_i,
  input  logic        [VALUE_WIDTH-2:0]        accel_limit_i,
  input  logic signed [VALUE_WIDTH-1:0]        position_error_i,
  input  logic signed [VALUE_WIDTH-1:0]        current_velocity_i,
  input  logic        [VALUE_WIDTH-5:0]        time_step_i,
  output logic        [2*VALUE_WIDTH-5:0]      step_o,
  output logic        [2*VALUE_WIDTH-1:0]      sq_o,
  output logic        [2*VALUE_WIDTH-1:0]      stop_o,
  output logic        [VALUE_WIDTH-1:0]        mag_o,
  output logic        [VALUE_WIDTH-1:0]        dx_o,
  output tvs_pkg::flags_t                      flags_o
);

  localparam int unsigned CW     = VALUE_WIDTH - 1;
  localparam int unsigned DW     = VALUE_WIDTH - 4;
  localparam int unsigned MW     = VALUE_WIDTH;
  localparam int unsigned STEP_W = 2 * VALUE_WIDTH - 4;
  localparam int unsigned SQ_W   = 2 * MW;
  localparam int unsigned PROD_W = CW + MW;

  tvs_pkg::flags_t     flags1_d, flags1_q;
  logic [MW-1:0]       dx1_d, dx1_q;
  logic [MW-1:0]       mag1_d, mag1_q;
  logic [DW-1:0]       dt1_q;

  logic [STEP_W-1:0]   step2_d, step2_q;
  logic [SQ_W-1:0]     sq2_d, sq2_q;
  logic [SQ_W-1:0]     stop2_d, stop2_q;
  logic [MW-1:0]       dx2_q;
  logic [MW-1:0]       mag2_q;
  tvs_pkg::flags_t     flags2_q;

  // Stage 1: signs and magnitudes. The most negative value maps to 2^(N-1).
  always_comb begin
    flags1_d.err_neg  = position_error_i[VALUE_WIDTH-1];
    flags1_d.err_zero = (position_error_i == '0);
    flags1_d.vel_neg  = current_velocity_i[VALUE_WIDTH-1];
    dx1_d  = flags1_d.err_neg ? (~$unsigned(position_error_i) + 1'b1)
                              : $unsigned(position_error_i);
    mag1_d = flags1_d.vel_neg ? (~$unsigned(current_velocity_i) + 1'b1)
                              : $unsigned(current_velocity_i);
  end

  always_ff @(posedge clk_i) begin
    if (load1_i) begin
      flags1_q <= flags1_d;
      dx1_q    <= dx1_d;
      mag1_q   <= mag1_d;
      dt1_q    <= time_step_i;
    end
  end

  // Stage 2: step = accel*dt (Q.32), v^2 and 2*accel*|error| (both Q.32).
  always_comb begin
    step2_d = STEP_W'(accel_limit_i) * STEP_W'(dt1_q);
    sq2_d   = SQ_W'(mag1_q) * SQ_W'(mag1_q);
    stop2_d = {PROD_W'(accel_limit_i) * PROD_W'(dx1_q), 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (load2_i) begin
      step2_q  <= step2_d;
      sq2_q    <= sq2_d;
      stop2_q  <= stop2_d;
      dx2_q    <= dx1_q;
      mag2_q   <= mag1_q;
      flags2_q <= flags1_q;
    end
  end

  assign step_o  = step2_q;
  assign sq_o    = sq2_q;
  assign stop_o  = stop2_q;
  assign mag_o   = mag2_q;
  assign dx_o    = dx2_q;
  assign flags_o = flags2_q;

endmodule

// ===== sv/tvs_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mode decision stage
// Stage 3 picks the profile mode and forms the raised and lowered speeds
// in Q.32 side by side.
// ----------------------------------------------------------------------------
module tvs_decide #(
  parameter int unsigned VALUE_WIDTH   = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   load3_i,
  input  logic        [VALUE_WIDTH-2:0]          velocity_limit_i,
  input  logic        [2*VALUE_WIDTH-5:0]        step_i,
  input  logic        [2*VALUE_WIDTH-1:0]        sq_i,
  input  logic        [2*VALUE_WIDTH-1:0]        stop_i,
  input  logic        [VALUE_WIDTH-1:0]          mag_i,
  input  logic        [VALUE_WIDTH-1:0]          dx_i,
  input  tvs_pkg::flags_t                        flags_i,
  output tvs_pkg::mode_e                         mode_o,
  output logic [((VALUE_WIDTH+FRACTION_BITS > 2*VALUE_WIDTH-4) ?
                 VALUE_WIDTH+FRACTION_BITS : 2*VALUE_WIDTH-4):0] sum_o,
  output logic        [VALUE_WIDTH+FRACTION_BITS-1:0] diff_o,
  output logic        [2*VALUE_WIDTH-5:0]        step_o,
  output logic        [VALUE_WIDTH-1:0]          mag_o,
  output tvs_pkg::flags_t                        flags_o
);

  localparam int unsigned MW     = VALUE_WIDTH;
  localparam int unsigned STEP_W = 2 * VALUE_WIDTH - 4;
  localparam int unsigned WIDE_W = MW + FRACTION_BITS;
  localparam int unsigned SUM_W  = ((WIDE_W > STEP_W) ? WIDE_W : STEP_W) + 1;
  localparam int unsigned DXS_W  = MW + FRACTION_BITS + 1;
  localparam int unsigned CMP_W  = (DXS_W > STEP_W) ? DXS_W : STEP_W;

  logic [WIDE_W-1:0]   wide;
  logic [CMP_W-1:0]    dx_scaled;
  logic [SUM_W-1:0]    diff_full;
  logic                is_still;
  logic                stop_reached;
  logic                behind;
  logic                at_limit;
  logic                below_step;

  tvs_pkg::mode_e      mode_d, mode_q;
  logic [SUM_W-1:0]    sum_d, sum_q;
  logic [WIDE_W-1:0]   diff_d, diff_q;
  logic [STEP_W-1:0]   step_q;
  logic [MW-1:0]       mag_q;
  tvs_pkg::flags_t     flags_q;

  // Compares that choose the mode.
  always_comb begin
    wide         = {mag_i, {FRACTION_BITS{1'b0}}};
    dx_scaled    = CMP_W'({dx_i, {(FRACTION_BITS + 1){1'b0}}});
    is_still     = (mag_i == '0) && (dx_scaled <= CMP_W'(step_i));
    stop_reached = (sq_i >= stop_i);
    behind       = (mag_i != '0) && (flags_i.vel_neg != flags_i.err_neg) &&
                   !flags_i.err_zero;
    at_limit     = (mag_i >= {1'b0, velocity_limit_i});
  end

  // Mode priority: still, then decelerate, then cruise, else accelerate.
  always_comb begin
    priority if (is_still) begin
      mode_d = tvs_pkg::MODE_STILL;
    end else if (stop_reached || behind) begin
      mode_d = tvs_pkg::MODE_DECEL;
    end else if (at_limit) begin
      mode_d = tvs_pkg::MODE_CONST;
    end else begin
      mode_d = tvs_pkg::MODE_ACCEL;
    end
  end

  // Raised speed and lowered speed clamped at zero.
  always_comb begin
    sum_d      = SUM_W'(wide) + SUM_W'(step_i);
    below_step = (SUM_W'(wide) <= SUM_W'(step_i));
    diff_full  = SUM_W'(wide) - SUM_W'(step_i);
    diff_d     = below_step ? '0 : diff_full[WIDE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load3_i) begin
      mode_q  <= mode_d;
      sum_q   <= sum_d;
      diff_q  <= diff_d;
      step_q  <= step_i;
      mag_q   <= mag_i;
      flags_q <= flags_i;
    end
  end

  assign mode_o  = mode_q;
  assign sum_o   = sum_q;
  assign diff_o  = diff_q;
  assign step_o  = step_q;
  assign mag_o   = mag_q;
  assign flags_o = flags_q;

endmodule

// ===== sv/tvs_shape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result shaping stages
// Stage 4 limits or snaps the new speed for its mode. Stage 5 rounds it to
// Q.16, applies the sign of the error and holds the result item.
// ----------------------------------------------------------------------------
module tvs_shape #(
  parameter int unsigned VALUE_WIDTH   = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   load4_i,
  input  logic                                   load5_i,
  input  logic        [VALUE_WIDTH-2:0]          velocity_limit_i,
  input  tvs_pkg::mode_e                         mode_i,
  input  logic [((VALUE_WIDTH+FRACTION_BITS > 2*VALUE_WIDTH-4) ?
                 VALUE_WIDTH+FRACTION_BITS : 2*VALUE_WIDTH-4):0] sum_i,
  input  logic        [VALUE_WIDTH+FRACTION_BITS-1:0] diff_i,
  input  logic        [2*VALUE_WIDTH-5:0]        step_i,
  input  logic        [VALUE_WIDTH-1:0]          mag_i,
  input  tvs_pkg::flags_t                        flags_i,
  output logic signed [VALUE_WIDTH-1:0]          new_velocity_o,
  output tvs_pkg::mode_e                         mode_o
);

  localparam int unsigned MW     = VALUE_WIDTH;
  localparam int unsigned CW     = VALUE_WIDTH - 1;
  localparam int unsigned STEP_W = 2 * VALUE_WIDTH - 4;
  localparam int unsigned WIDE_W = MW + FRACTION_BITS;
  localparam int unsigned SUM_W  = ((WIDE_W > STEP_W) ? WIDE_W : STEP_W) + 1;
  localparam int unsigned LIM_W  = CW + FRACTION_BITS;
  localparam int unsigned SNAP_W = ((WIDE_W + 1) > STEP_W) ? (WIDE_W + 1) : STEP_W;
  localparam int unsigned RND_W  = WIDE_W + 1;

  logic [LIM_W-1:0]    lim;
  logic                over_limit;
  logic                snap_zero;
  logic [RND_W-1:0]    rnd_full;
  logic [MW-1:0]       mag_r;
  logic [MW-1:0]       max_pos;
  logic [MW-1:0]       min_neg;

  logic [WIDE_W-1:0]   wide4_d, wide4_q;
  tvs_pkg::mode_e      mode4_q;
  tvs_pkg::flags_t     flags4_q;

  logic [MW-1:0]       vel5_d, vel5_q;
  tvs_pkg::mode_e      mode5_q;

  // Stage 4: limit the raised speed, snap small lowered speeds to zero.
  always_comb begin
    lim        = {velocity_limit_i, {FRACTION_BITS{1'b0}}};
    over_limit = (sum_i > SUM_W'(lim));
    snap_zero  = (SNAP_W'({diff_i, 1'b0}) < SNAP_W'(step_i));
    unique case (mode_i)
      tvs_pkg::MODE_ACCEL: wide4_d = over_limit ? WIDE_W'(lim) : sum_i[WIDE_W-1:0];
      tvs_pkg::MODE_DECEL: wide4_d = snap_zero ? '0 : diff_i;
      tvs_pkg::MODE_CONST: wide4_d = {mag_i, {FRACTION_BITS{1'b0}}};
      tvs_pkg::MODE_STILL: wide4_d = '0;
      default:             wide4_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load4_i) begin
      wide4_q  <= wide4_d;
      mode4_q  <= mode_i;
      flags4_q <= flags_i;
    end
  end

  // Stage 5: round half up to Q.16, then sign and saturate.
  always_comb begin
    rnd_full = RND_W'(wide4_q) + (RND_W'(1) << (FRACTION_BITS - 1));
    mag_r    = rnd_full[FRACTION_BITS +: MW];
    max_pos  = {1'b0, {(MW - 1){1'b1}}};
    min_neg  = {1'b1, {(MW - 1){1'b0}}};
    priority if (flags4_q.err_zero) begin
      vel5_d = '0;
    end else if (!flags4_q.err_neg) begin
      vel5_d = (mag_r > max_pos) ? max_pos : mag_r;
    end else if (mag_r > min_neg) begin
      vel5_d = min_neg;
    end else begin
      vel5_d = ~mag_r + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load5_i) begin
      vel5_q  <= vel5_d;
      mode5_q <= mode4_q;
    end
  end

  assign new_velocity_o = $signed(vel5_q);
  assign mode_o         = mode5_q;

endmodule

// ===== tb/sv/tvs_velocity_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoidal velocity step checker
// Watches the configuration, input and result channels, keeps its own copy of
// the limits, predicts the result of every accepted item and compares it in
// order against the results the block hands out.
// ----------------------------------------------------------------------------
module tvs_velocity_checker #(
  parameter int unsigned VALUE_WIDTH   = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [VALUE_WIDTH-2:0]           cfg_data_i,
  // Input item channel
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [VALUE_WIDTH-1:0]    position_error_i,
  input  logic signed [VALUE_WIDTH-1:0]    current_velocity_i,
  input  logic [VALUE_WIDTH-5:0]           time_step_i,
  // Result item channel
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [VALUE_WIDTH-1:0]    new_velocity_i,
  input  logic [1:0]                       profile_mode_i,
  // Status toward the testbench top
  output int unsigned                      mismatch_count_o,
  output int unsigned                      pending_count_o
);

  localparam int unsigned CFG_W      = VALUE_WIDTH - 1;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic [63:0] MAX_POS    = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] NEG_MAG    = 64'd1 << (VALUE_WIDTH - 1);
  localparam logic [63:0] HALF_LSB   = 64'd1 << (FRACTION_BITS - 1);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] velocity;
    tvs_pkg::mode_e                mode;
  } velocity_result_t;

  // Shadow copy of the limit registers.
  logic [CFG_W-1:0] velocity_limit_q;
  logic [CFG_W-1:0] accel_limit_q;

  // Predicted results, oldest first.
  velocity_result_t velocity_expected_q[$];

  // Next velocity and profile mode for one item under the present limits.
  // Speeds are held in Q.16 and the raised or lowered speed in Q.32.
  function automatic velocity_result_t next_velocity(
    input logic signed [VALUE_WIDTH-1:0] pos_err,
    input logic signed [VALUE_WIDTH-1:0] vel,
    input logic [VALUE_WIDTH-5:0]        dt
  );
    logic signed [63:0] err_w;
    logic signed [63:0] vel_w;
    logic [63:0]        err_mag;
    logic [63:0]        speed;
    logic [63:0]        step;
    logic [63:0]        wide;
    logic [63:0]        lim;
    logic [63:0]        signed_speed;
    tvs_pkg::mode_e     chosen;
    velocity_result_t   res;
    err_w   = pos_err;
    vel_w   = vel;
    err_mag = (err_w < 0) ? -err_w : err_w;
    speed   = (vel_w < 0) ? -vel_w : vel_w;
    step    = 64'(accel_limit_q) * 64'(dt);
    wide    = speed << FRACTION_BITS;
    lim     = 64'(velocity_limit_q) << FRACTION_BITS;

    if (speed == 64'd0 && ((err_mag << FRACTION_BITS) << 1) <= step) begin
      // At rest and close enough to stay there.
      res.velocity = '0;
      res.mode     = tvs_pkg::MODE_STILL;
    end else begin
      // Stopping distance reached, or moving away from the target.
      if (speed * speed >= 64'd2 * 64'(accel_limit_q) * err_mag) begin
        chosen = tvs_pkg::MODE_DECEL;
      end else if (speed != 64'd0 && ((vel_w < 0) != (err_w < 0)) && err_w != 0) begin
        chosen = tvs_pkg::MODE_DECEL;
      end else if (speed >= 64'(velocity_limit_q)) begin
        chosen = tvs_pkg::MODE_CONST;
      end else begin
        chosen = tvs_pkg::MODE_ACCEL;
      end

      case (chosen)
        tvs_pkg::MODE_ACCEL: begin
          wide = wide + step;
          if (wide > lim) begin
            wide = lim;
          end
          speed = (wide + HALF_LSB) >> FRACTION_BITS;
        end
        tvs_pkg::MODE_DECEL: begin
          wide = (wide <= step) ? 64'd0 : wide - step;
          // Less than half a step left snaps to a standstill.
          if ((wide << 1) < step) begin
            wide = 64'd0;
          end
          speed = (wide + HALF_LSB) >> FRACTION_BITS;
        end
        default: begin
        end
      endcase

      // Sign follows the error; the magnitude saturates to the value range.
      if (err_w > 0) begin
        signed_speed = (speed > MAX_POS) ? MAX_POS : speed;
      end else if (err_w < 0) begin
        signed_speed = (speed > NEG_MAG) ? -NEG_MAG : -speed;
      end else begin
        signed_speed = 64'd0;
      end
      res.velocity = signed_speed[VALUE_WIDTH-1:0];
      res.mode     = chosen;
    end
    return res;
  endfunction

  // Track register writes, check results in order and queue new predictions.
  always @(posedge clk_i or negedge rst_ni) begin
    velocity_result_t want;
    if (!rst_ni) begin
      velocity_limit_q = CFG_W'(tvs_pkg::VEL_LIMIT_RESET);
      accel_limit_q    = CFG_W'(tvs_pkg::ACC_LIMIT_RESET);
      velocity_expected_q.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == tvs_pkg::CFG_VEL_LIMIT) begin
          velocity_limit_q = cfg_data_i;
        end else if (cfg_index_i == tvs_pkg::CFG_ACC_LIMIT) begin
          accel_limit_q = cfg_data_i;
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (velocity_expected_q.size() == 0) begin
          if (mismatch_count_o < REPORT_MAX) begin
            $display("%0t: result item with none expected: velocity %0d mode %0d",
                     $time, new_velocity_i, profile_mode_i);
          end
          mismatch_count_o++;
        end else begin
          want = velocity_expected_q.pop_front();
          if (want.velocity !== new_velocity_i || want.mode !== profile_mode_i) begin
            if (mismatch_count_o < REPORT_MAX) begin
              $display({"%0t: result mismatch: expected velocity %0d mode %0d, ",
                        "got velocity %0d mode %0d"},
                       $time, $signed(want.velocity), want.mode, new_velocity_i,
                       profile_mode_i);
            end
            mismatch_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        velocity_expected_q = {velocity_expected_q,
                               next_velocity(position_error_i, current_velocity_i,
                                             time_step_i)};
      end
      pending_count_o = velocity_expected_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_trapezoidal_velocity_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoidal velocity step testbench
// Drives directed and random items through several limit settings with a
// bursty sender and a stalling receiver; the checker predicts and compares
// every result item and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_trapezoidal_velocity_step;

  localparam int unsigned VW              = 24;
  localparam int unsigned FB              = 16;
  localparam int unsigned CFG_W           = VW - 1;
  localparam int unsigned DT_W            = VW - 4;
  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned PHASES          = 7;
  localparam int unsigned ITEMS_PER_PHASE = 176;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned IDLE_LIMIT      = 5000;
  localparam int unsigned DRAIN_CYCLES    = 4 * tvs_pkg::PIPE_STAGES;
  localparam logic [63:0] MAX_MAG         = (64'd1 << (VW - 1)) - 64'd1;
  localparam logic [CFG_W-1:0] CFG_MAX    = '1;
  localparam logic signed [VW-1:0] MOST_POS = {1'b0, {(VW - 1){1'b1}}};
  localparam logic signed [VW-1:0] MOST_NEG = {1'b1, {(VW - 1){1'b0}}};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [tvs_pkg::CFG_IDX_W-1:0] cfg_index = tvs_pkg::CFG_VEL_LIMIT;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VW-1:0]    position_error = '0;
  logic signed [VW-1:0]    current_velocity = '0;
  logic [DT_W-1:0]         time_step = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VW-1:0]    new_velocity;
  logic [1:0]              profile_mode;
  int unsigned             mismatch_count;
  int unsigned             pending_results;

  // Limits last written, used to aim the random items.
  logic [CFG_W-1:0]        vel_limit_set = CFG_W'(tvs_pkg::VEL_LIMIT_RESET);
  logic [CFG_W-1:0]        acc_limit_set = CFG_W'(tvs_pkg::ACC_LIMIT_RESET);

  // Long receiver hold-offs asked by the sender and carried out by the sink.
  int unsigned             hold_requests = 0;
  int unsigned             holds_done = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  trapezoidal_velocity_step #(
    .VALUE_WIDTH   (VW),
    .FRACTION_BITS (FB)
  ) DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .position_error_i   (position_error),
    .current_velocity_i (current_velocity),
    .time_step_i        (time_step),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .new_velocity_o     (new_velocity),
    .profile_mode_o     (profile_mode)
  );

  tvs_velocity_checker #(
    .VALUE_WIDTH   (VW),
    .FRACTION_BITS (FB)
  ) u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .position_error_i   (position_error),
    .current_velocity_i (current_velocity),
    .time_step_i        (time_step),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .new_velocity_i     (new_velocity),
    .profile_mode_i     (profile_mode),
    .mismatch_count_o   (mismatch_count),
    .pending_count_o    (pending_results)
  );

  // Random value of random bit width, so small magnitudes come up often.
  function automatic logic [63:0] rand_bits(input int unsigned max_width);
    int unsigned width;
    width = $urandom_range(1, max_width);
    return 64'($urandom) & ((64'd1 << width) - 64'd1);
  endfunction

  function automatic logic [63:0] clamp_mag(input logic [63:0] value);
    return (value > MAX_MAG) ? MAX_MAG : value;
  endfunction

  // Offer one item; called at a falling edge, returns at the falling edge
  // after acceptance with valid still high.
  task automatic send_item(input logic signed [VW-1:0] err, input logic signed [VW-1:0] vel,
                           input logic [DT_W-1:0] dt);
    in_valid         <= 1'b1;
    position_error   <= err;
    current_velocity <= vel;
    time_step        <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one limit register; the caller lowers valid after the last write.
  task automatic write_reg(input logic [tvs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Pause the sender until every predicted result has come back.
  task automatic wait_drained();
    while (pending_results != 0) @(negedge clk);
    repeat (tvs_pkg::PIPE_STAGES) @(negedge clk);
  endtask

  // One random item, mostly aimed at the mode boundaries of the present limits.
  task automatic make_random_item(output logic signed [VW-1:0] err,
                                  output logic signed [VW-1:0] vel,
                                  output logic [DT_W-1:0] dt);
    int unsigned kind;
    logic        neg;
    logic [31:0] raw;
    logic [63:0] err_mag;
    logic [63:0] speed;
    logic [63:0] bound;
    kind    = $urandom_range(0, 99);
    neg     = 1'($urandom_range(0, 1));
    raw     = 32'(rand_bits(DT_W));
    dt      = raw[DT_W-1:0];
    err_mag = rand_bits(VW - 1);
    speed   = rand_bits(VW - 1);
    if (kind < 15) begin
      // Unshaped noise over the whole field ranges.
      raw = $urandom;
      err = raw[VW-1:0];
      raw = $urandom;
      vel = raw[VW-1:0];
      raw = $urandom;
      dt  = raw[DT_W-1:0];
    end else begin
      if (kind < 27) begin
        // At rest near the edge of the standstill window.
        bound   = clamp_mag((64'(acc_limit_set) * 64'(dt)) >> (FB + 1));
        err_mag = clamp_mag(64'($urandom) % (bound + 64'd2));
        speed   = 64'd0;
      end else if (kind < 32) begin
        err_mag = 64'd0;
      end else if (kind < 37) begin
        speed = 64'd0;
      end else if (kind < 72) begin
        // Moving at or around the velocity limit with short time steps.
        speed = 64'($urandom_range(0, 32'(clamp_mag(64'(vel_limit_set) +
                                                    64'(vel_limit_set >> 3) + 64'd4))));
        raw   = 32'(rand_bits(14));
        dt    = raw[DT_W-1:0];
      end else begin
        // Error close to the stopping distance.
        err_mag = (speed * speed) / (64'd2 * 64'(acc_limit_set));
        err_mag = err_mag + 64'($urandom_range(0, 4));
        err_mag = clamp_mag((err_mag > 64'd2) ? err_mag - 64'd2 : 64'd0);
        raw     = 32'(rand_bits(16));
        dt      = raw[DT_W-1:0];
      end
      err = err_mag[VW-1:0];
      vel = speed[VW-1:0];
      if (neg) begin
        err = -err;
      end
      // Mostly moving toward the target, sometimes away from it.
      if (neg ^ ($urandom_range(0, 9) == 0)) begin
        vel = -vel;
      end
    end
  endtask

  // Random items in bursts with random gaps; ends with valid low.
  task automatic run_random(input int unsigned count, input logic with_hold);
    int unsigned          sent;
    int unsigned          burst;
    int unsigned          gap;
    logic signed [VW-1:0] err;
    logic signed [VW-1:0] vel;
    logic [DT_W-1:0]      dt;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      while (burst != 0 && sent < count) begin
        if (with_hold && sent == count / 3) begin
          hold_requests++;
        end
        make_random_item(err, vel, dt);
        send_item(err, vel, dt);
        sent++;
        burst--;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned      phase;
    logic [CFG_W-1:0] vel_lim;
    logic [CFG_W-1:0] acc_lim;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        // Directed items under the reset limits.
        send_item(24'sd100, 24'sd0, 20'd65536);          // still, small error
        send_item(24'sd11469, 24'sd0, 20'd65536);        // still, window edge
        send_item(-24'sd11469, 24'sd0, 20'd65536);       // still, negative edge
        send_item(24'sd11470, 24'sd0, 20'd65536);        // just outside the window
        send_item(24'sd0, 24'sd0, 20'd0);                // nothing to do
        send_item(24'sd655360, 24'sd0, 20'd6554);        // accelerate from rest
        send_item(24'sd655360, 24'sd26000, 20'd65536);   // accelerate into the limit
        send_item(MOST_POS, 24'sd26214, 20'd6554);       // cruise at the limit
        send_item(MOST_POS, 24'sd30000, 20'd6554);       // cruise above the limit
        send_item(24'sd65536, 24'sd65536, 20'd6554);     // stopping distance reached
        send_item(-24'sd655360, 24'sd13107, 20'd6554);   // target behind
        send_item(24'sd1, 24'sd30000, 20'd65536);        // snap to standstill
        send_item(24'sd0, 24'sd13107, 20'd6554);         // zero error while moving
        send_item(24'sd0, -24'sd13107, 20'd6554);
        send_item(MOST_POS, MOST_NEG, 20'd0);            // result saturates high
        send_item(MOST_NEG, MOST_NEG, 20'd0);            // most negative result
        send_item(MOST_NEG, MOST_POS, 20'hFFFFF);
        send_item(MOST_POS, MOST_POS, 20'hFFFFF);
        send_item(-24'sd1, -24'sd1, 20'd0);
        send_item(-24'sd655360, -24'sd13107, 20'd6554);  // accelerate backward
        send_item(MOST_POS, 24'sd0, 20'hFFFFF);          // long step from rest
        send_item(-24'sd3, 24'sd0, 20'd2);
      end else begin
        wait_drained();
        case (phase)
          1: begin
            vel_lim = CFG_MAX;
            acc_lim = CFG_MAX;
          end
          2: begin
            vel_lim = '0;
            acc_lim = CFG_W'(1);
          end
          3: begin
            vel_lim = CFG_MAX;
            acc_lim = CFG_W'(1);
          end
          4: begin
            vel_lim = '0;
            acc_lim = CFG_MAX;
          end
          5: begin
            vel_lim = CFG_W'(rand_bits(CFG_W));
            acc_lim = CFG_W'(rand_bits(CFG_W));
            if (acc_lim == '0) begin
              acc_lim = CFG_W'(1);
            end
          end
          default: begin
            vel_lim = CFG_W'($urandom_range(1000, 200000));
            acc_lim = CFG_W'($urandom_range(1000, 200000));
          end
        endcase
        write_reg(tvs_pkg::CFG_VEL_LIMIT, vel_lim);
        write_reg(tvs_pkg::CFG_ACC_LIMIT, acc_lim);
        cfg_valid     <= 1'b0;
        vel_limit_set = vel_lim;
        acc_limit_set = acc_lim;
      end
      run_random(ITEMS_PER_PHASE, phase == 1 || phase == 5);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb_trapezoidal_velocity_step: PASS");
    end else begin
      $display("tb_trapezoidal_velocity_step: FAIL");
    end
    $finish;
  end

  // Result sink: stretches of full, random, sparse and dense ready, plus the
  // long hold-offs that fill the pipeline and stall the input.
  initial begin : result_sink
    int unsigned kind;
    int unsigned stretch;
    logic        rdy;
    @(negedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        kind    = $urandom_range(0, 3);
        stretch = $urandom_range(1, 40);
        repeat (stretch) begin
          case (kind)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = ($urandom_range(0, 3) != 0);
          endcase
          out_ready <= rdy;
          @(negedge clk);
        end
      end
    end
  end

  // Watchdog: too many cycles without any handshake ends the run.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_trapezoidal_velocity_step: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tvs_pkg.sv
sv/tvs_front.sv
sv/tvs_decide.sv
sv/tvs_shape.sv
sv/trapezoidal_velocity_step.sv
tb/sv/tvs_velocity_checker.sv
tb/sv/tb_trapezoidal_velocity_step.sv
